// ===== src/dsbt_pkg.sv =====
// Shared types, constants and helper functions for the date string decoder.
`default_nettype none

package dsbt_pkg;

    localparam int MAX_CHARS_DEFAULT = 32;

    // Highest character position any layout reads is 30, so only 31 are kept.
    localparam int CAPTURE_LEN = 31;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register map
    localparam int ADDR_W = 1;
    localparam logic [ADDR_W-1:0] REG_FORMAT_ADDR = 1'b0;

    localparam logic FMT_ISO  = 1'b0;
    localparam logic FMT_HTTP = 1'b1;

    // One decoded string as handed from the front end to the back end.
    typedef struct packed {
        logic       is_http;
        logic [7:0] yr_a;
        logic [7:0] yr_b;
        logic [7:0] mo_a;
        logic [7:0] mo_b;
        logic [3:0] mo_code;
        logic [2:0] wd_code;
        logic [7:0] dy_a;
        logic [7:0] dy_b;
        logic [7:0] hr_a;
        logic [7:0] hr_b;
        logic [7:0] mi_a;
        logic [7:0] mi_b;
        logic [7:0] se_a;
        logic [7:0] se_b;
    } entry_t;

    typedef struct packed {
        logic       neg;
        logic [7:0] val;
    } pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Two-character number as atoi reads it, kept mod 256.
    function automatic pair_t pair_val(input logic [7:0] a, input logic [7:0] b);
        pair_t      p;
        logic [7:0] da;
        logic [7:0] db;
        da = a - 8'h30;
        db = b - 8'h30;
        p.neg = 1'b0;
        p.val = 8'h00;
        if (is_space(a))
        begin
            if (is_digit(b))
            begin
                p.val = db;
            end
        end
        else if (is_digit(a))
        begin
            if (is_digit(b))
            begin
                p.val = 8'((da << 3) + (da << 1) + db);
            end
            else
            begin
                p.val = da;
            end
        end
        else if (a == 8'h2B && is_digit(b))
        begin
            p.val = db;
        end
        else if (a == 8'h2D && is_digit(b))
        begin
            p.val = 8'h00 - db;
            p.neg = (db != 8'h00);
        end
        return p;
    endfunction

    // Binary to BCD; tens digit kept mod 16. d/10 via reciprocal 205/2048.
    function automatic logic [7:0] to_bcd(input logic [7:0] d);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 16'(d) * 16'd205;
        q = prod[15:11];
        r = d - 8'((q << 3) + (q << 1));
        return {q[3:0], r[3:0]};
    endfunction

endpackage

`default_nettype wire

// ===== src/dsbt_front.sv =====
// Front end: captures characters by position and classifies the finished string.
`default_nettype none

module dsbt_front #(
    parameter int MAX_CHARS = dsbt_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_byte,
    input  logic                start_of_string,
    input  logic                end_of_string,
    input  logic                format_select,
    input  logic                q_full,
    output logic                push,
    output dsbt_pkg::entry_t    entry
);

    localparam int PW = $clog2(MAX_CHARS + 1);
    localparam int HTTP_PREFIX = 6;

    logic [7:0]                       store_reg [dsbt_pkg::CAPTURE_LEN];
    logic [dsbt_pkg::CAPTURE_LEN-1:0] valid_reg;
    logic [dsbt_pkg::CAPTURE_LEN-1:0] valid_next;
    logic [PW-1:0]                    pos_reg;
    logic [PW-1:0]                    pos_next;
    logic [PW-1:0]                    pos_eff;
    logic                             wr_en;
    logic                             accept;
    logic [7:0]                       snap [dsbt_pkg::CAPTURE_LEN];
    logic [7:0]                       h [25];
    logic                             has_prefix;

    // Only a final character needs a queue slot.
    assign in_ready = !end_of_string || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && end_of_string;

    assign pos_eff = start_of_string ? '0 : pos_reg;
    assign wr_en   = (pos_eff < PW'(MAX_CHARS));

    // Store contents as they stand once this character is captured.
    always_comb
    begin
        for (int i = 0; i < dsbt_pkg::CAPTURE_LEN; i++)
        begin
            if (wr_en && pos_eff == PW'(i))
            begin
                snap[i] = char_byte;
            end
            else if (start_of_string || !valid_reg[i])
            begin
                snap[i] = 8'h00;
            end
            else
            begin
                snap[i] = store_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < dsbt_pkg::CAPTURE_LEN; i++)
        begin
            valid_next[i] = !end_of_string &&
                            ((!start_of_string && valid_reg[i]) ||
                             (wr_en && pos_eff == PW'(i)));
        end
        if (end_of_string)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_eff + PW'(wr_en);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dsbt_pkg::CAPTURE_LEN; i++)
        begin
            if (accept && wr_en && pos_eff == PW'(i))
            begin
                store_reg[i] <= char_byte;
            end
        end
    end

    // HTTP layout, shifted past an optional "Date: " prefix.
    assign has_prefix = (snap[0] == 8'h44);

    always_comb
    begin
        for (int i = 0; i < 25; i++)
        begin
            h[i] = has_prefix ? snap[i + HTTP_PREFIX] : snap[i];
        end
    end

    always_comb
    begin
        entry.is_http = (format_select == dsbt_pkg::FMT_HTTP);

        case (h[0])
            8'h54:   entry.wd_code = (h[1] == 8'h75) ? 3'd2 : 3'd4;
            8'h53:   entry.wd_code = (h[1] == 8'h61) ? 3'd6 : 3'd0;
            8'h4D:   entry.wd_code = 3'd1;
            8'h57:   entry.wd_code = 3'd3;
            default: entry.wd_code = 3'd5;
        endcase

        case (h[8])
            8'h4A:
            begin
                if (h[9] == 8'h61)
                begin
                    entry.mo_code = 4'd1;
                end
                else
                begin
                    entry.mo_code = (h[10] == 8'h6E) ? 4'd6 : 4'd7;
                end
            end
            8'h46:   entry.mo_code = 4'd2;
            8'h4D:   entry.mo_code = (h[10] == 8'h72) ? 4'd3 : 4'd5;
            8'h41:   entry.mo_code = (h[9] == 8'h70) ? 4'd4 : 4'd8;
            8'h53:   entry.mo_code = 4'd9;
            8'h4F:   entry.mo_code = 4'd10;
            8'h4E:   entry.mo_code = 4'd11;
            default: entry.mo_code = 4'd12;
        endcase

        entry.mo_a = snap[5];
        entry.mo_b = snap[6];

        if (entry.is_http)
        begin
            entry.yr_a = h[14];
            entry.yr_b = h[15];
            entry.dy_a = h[5];
            entry.dy_b = h[6];
            entry.hr_a = h[17];
            entry.hr_b = h[18];
            entry.mi_a = h[20];
            entry.mi_b = h[21];
            entry.se_a = h[23];
            entry.se_b = h[24];
        end
        else
        begin
            entry.yr_a = snap[2];
            entry.yr_b = snap[3];
            entry.dy_a = snap[8];
            entry.dy_b = snap[9];
            entry.hr_a = snap[11];
            entry.hr_b = snap[12];
            entry.mi_a = snap[14];
            entry.mi_b = snap[15];
            entry.se_a = snap[17];
            entry.se_b = snap[18];
        end
    end

endmodule

`default_nettype wire

// ===== src/dsbt_queue.sv =====
// Small FIFO between the front end and the back end.
`default_nettype none

module dsbt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dsbt_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output dsbt_pkg::entry_t head
);

    localparam int AW = $clog2(dsbt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(dsbt_pkg::QUEUE_DEPTH + 1);

    dsbt_pkg::entry_t mem [dsbt_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;

    assign full      = (count_reg == CW'(dsbt_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(dsbt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(dsbt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/dsbt_back.sv =====
// Back end: range-checks the fields in order, updates the BCD time store, holds the result.
`default_nettype none

module dsbt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  dsbt_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       year_bcd,
    output logic [7:0]       month_bcd,
    output logic [7:0]       day_bcd,
    output logic [7:0]       weekday,
    output logic [7:0]       hour_bcd,
    output logic [7:0]       minute_bcd,
    output logic [7:0]       second_bcd,
    output logic [7:0]       hundredth_bcd,
    output logic             ok
);

    dsbt_pkg::pair_t yr_p;
    dsbt_pkg::pair_t mo_p;
    dsbt_pkg::pair_t dy_p;
    dsbt_pkg::pair_t hr_p;
    dsbt_pkg::pair_t mi_p;
    dsbt_pkg::pair_t se_p;
    logic [7:0]      mo_val;
    logic [7:0]      dy_val;
    logic [7:0]      wd_val;
    logic [7:0]      hr_val;
    logic [7:0]      mi_val;
    logic [7:0]      se_val;
    logic [6:0]      pass;

    logic [7:0] year_reg;
    logic [7:0] month_reg;
    logic [7:0] day_reg;
    logic [7:0] wd_reg;
    logic [7:0] hour_reg;
    logic [7:0] min_reg;
    logic [7:0] sec_reg;
    logic       ok_reg;
    logic       out_valid_reg;

    // The time store only changes on a pop, so it doubles as the output register.
    assign pop = q_not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        yr_p   = dsbt_pkg::pair_val(head.yr_a, head.yr_b);
        mo_p   = dsbt_pkg::pair_val(head.mo_a, head.mo_b);
        dy_p   = dsbt_pkg::pair_val(head.dy_a, head.dy_b);
        hr_p   = dsbt_pkg::pair_val(head.hr_a, head.hr_b);
        mi_p   = dsbt_pkg::pair_val(head.mi_a, head.mi_b);
        se_p   = dsbt_pkg::pair_val(head.se_a, head.se_b);
        mo_val = head.is_http ? {4'h0, head.mo_code} : mo_p.val;
        wd_val = head.is_http ? {5'h00, head.wd_code} : 8'h00;
        dy_val = dy_p.val;
        hr_val = hr_p.val;
        mi_val = mi_p.val;
        se_val = se_p.val;

        // Checking stops at the first field out of range.
        pass[0] = !(head.is_http && yr_p.neg);
        pass[1] = pass[0] && (mo_val inside {[8'd1:8'd12]});
        pass[2] = pass[1] && (dy_val inside {[8'd1:8'd31]});
        pass[3] = pass[2] && (wd_val <= 8'd6);
        pass[4] = pass[3] && (hr_val <= 8'd23);
        pass[5] = pass[4] && (mi_val <= 8'd59);
        pass[6] = pass[5] && (se_val <= 8'd59);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            wd_reg        <= '0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (pass[0]) year_reg  <= dsbt_pkg::to_bcd(yr_p.val);
                if (pass[1]) month_reg <= dsbt_pkg::to_bcd(mo_val);
                if (pass[2]) day_reg   <= dsbt_pkg::to_bcd(dy_val);
                if (pass[3]) wd_reg    <= wd_val;
                if (pass[4]) hour_reg  <= dsbt_pkg::to_bcd(hr_val);
                if (pass[5]) min_reg   <= dsbt_pkg::to_bcd(mi_val);
                if (pass[6]) sec_reg   <= dsbt_pkg::to_bcd(se_val);
                ok_reg        <= pass[6];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign year_bcd      = year_reg;
    assign month_bcd     = month_reg;
    assign day_bcd       = day_reg;
    assign weekday       = wd_reg;
    assign hour_bcd      = hour_reg;
    assign minute_bcd    = min_reg;
    assign second_bcd    = sec_reg;
    // Hundredths are only ever written with zero.
    assign hundredth_bcd = 8'h00;
    assign ok            = ok_reg;

endmodule

`default_nettype wire

// ===== src/date_string_to_bcd_time.sv =====
// Top level of the date string to BCD time decoder.
`default_nettype none

// Takes one character of a fixed-layout date string per transfer (ISO 8601
// or HTTP date, chosen by format_select at address 0) and, on the character
// marked end_of_string, decodes it into BCD time fields plus an ok flag.
// One character is taken every cycle unless the input stalls; after the last
// character transfers, out_valid rises via a two-entry queue and the result
// register of the back end. The input stalls only on a final character while
// that queue is full. A new string may follow its predecessor with no gap.
// Characters past MAX_CHARS are dropped; only the first 31 are ever decoded.
module date_string_to_bcd_time #(
    parameter int MAX_CHARS = dsbt_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsbt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  char_byte,
    input  logic                        start_of_string,
    input  logic                        end_of_string,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  year_bcd,
    output logic [7:0]                  month_bcd,
    output logic [7:0]                  day_bcd,
    output logic [7:0]                  weekday,
    output logic [7:0]                  hour_bcd,
    output logic [7:0]                  minute_bcd,
    output logic [7:0]                  second_bcd,
    output logic [7:0]                  hundredth_bcd,
    output logic                        ok
);

    logic             fmt_reg;
    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    dsbt_pkg::entry_t entry;
    dsbt_pkg::entry_t head;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= dsbt_pkg::FMT_ISO;
        end
        else if (psel && penable && pwrite && paddr == dsbt_pkg::REG_FORMAT_ADDR)
        begin
            fmt_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == dsbt_pkg::REG_FORMAT_ADDR) ? {31'h0, fmt_reg} : 32'h0;

    dsbt_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_byte      (char_byte),
        .start_of_string(start_of_string),
        .end_of_string  (end_of_string),
        .format_select  (fmt_reg),
        .q_full         (q_full),
        .push           (push),
        .entry          (entry)
    );

    dsbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(entry),
        .full     (q_full),
        .pop      (pop),
        .not_empty(q_not_empty),
        .head     (head)
    );

    dsbt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .year_bcd     (year_bcd),
        .month_bcd    (month_bcd),
        .day_bcd      (day_bcd),
        .weekday      (weekday),
        .hour_bcd     (hour_bcd),
        .minute_bcd   (minute_bcd),
        .second_bcd   (second_bcd),
        .hundredth_bcd(hundredth_bcd),
        .ok           (ok)
    );

endmodule

`default_nettype wire

// ===== sim/tb_date_string_to_bcd_time.sv =====
// Self-checking testbench for the date string to BCD time decoder.
`timescale 1ns / 100ps

module tb_date_string_to_bcd_time;

    localparam int MAX_CHARS      = 32;
    localparam int IDLE_PCT       = 30;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_CHARS   = 230;
    localparam int RANDOM_DECODES = 8;
    localparam int PHASE_STRINGS  = 5;
    localparam int DIR_ROWS       = 25;
    localparam int MAX_REPORTS    = 40;

    localparam logic [7:0] ASCII_ZERO = "0";

    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] wday;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] hundredth;
        logic       ok;
    } bcd_time_t;

    typedef struct {
        logic      fmt;
        string     text;
        bit        marked;
        bit        pinned;
        bcd_time_t want;
    } date_row_t;

    localparam logic [7:0] FIELD_LO [8] = '{0, 1, 1, 0, 0, 0, 0, 0};
    localparam logic [7:0] FIELD_HI [8] = '{255, 12, 31, 6, 23, 59, 59, 99};

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dsbt_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [7:0]                    char_byte;
    logic                          start_of_string;
    logic                          end_of_string;
    logic                          out_valid;
    logic                          out_ready;
    logic [7:0]                    year_bcd;
    logic [7:0]                    month_bcd;
    logic [7:0]                    day_bcd;
    logic [7:0]                    weekday;
    logic [7:0]                    hour_bcd;
    logic [7:0]                    minute_bcd;
    logic [7:0]                    second_bcd;
    logic [7:0]                    hundredth_bcd;
    logic                          ok;

    // Decoder shadow state
    logic       fmt_http;
    logic [7:0] char_mem [MAX_CHARS];
    int         char_pos;
    logic [7:0] held [8];
    logic [7:0] cand [8];

    bcd_time_t  times_due [$];
    bit         pinned;
    bcd_time_t  pinned_want;

    logic [7:0] line_chars [$];
    bit         calm;

    int errors;
    int chars_taken;
    int decodes;
    int fails;
    int results_seen;
    int reg_writes;
    int strings_sent;
    int quiet_cycles;

    string wd_names [8] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Xyz"};
    string mo_names [13] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun", "Jul", "Aug",
                             "Sep", "Oct", "Nov", "Dec", "Qqq"};

    date_row_t date_rows [DIR_ROWS] = '{
        '{dsbt_pkg::FMT_ISO, "2018-01-01T08:00:00", 1'b1, 1'b1,
          {8'h18, 8'h01, 8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{dsbt_pkg::FMT_ISO, "2099-12-31T23:59:59", 1'b1, 1'b1,
          {8'h99, 8'h12, 8'h31, 8'h00, 8'h23, 8'h59, 8'h59, 8'h00, 1'b1}},
        '{dsbt_pkg::FMT_ISO, "2000-01-01T00:00:00", 1'b1, 1'b1,
          {8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{dsbt_pkg::FMT_ISO, "2018-13-01T00:00:00", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "20-5-06-07T01:02:03", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "20 9-+3- 7T 1:+2:-0", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "2018-01-01T08:00:\3779", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "20", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "2021-06-15T12:30:45", 1'b0, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Date: Mon, 01 Jan 2018 08:00:00 GMT", 1'b1, 1'b1,
          {8'h18, 8'h01, 8'h01, 8'h01, 8'h08, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{dsbt_pkg::FMT_HTTP, "Sun, 31 Dec 2099 23:59:59 GMT", 1'b1, 1'b1,
          {8'h99, 8'h12, 8'h31, 8'h00, 8'h23, 8'h59, 8'h59, 8'h00, 1'b1}},
        '{dsbt_pkg::FMT_HTTP, "Tue, 14 Feb 2023 10:20:30 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Wed, 15 Mar 2023 11:21:31 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Thu, 13 Apr 2023 12:22:32 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Fri, 12 May 2023 13:23:33 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Sat, 10 Jun 2023 14:24:34 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Xyz, 11 Jul 2023 15:25:35 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Date: Mon, 21 Aug 2023 16:26:36 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Tue, 22 Sep 2023 17:27:37 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Wed, 23 Oct 2023 18:28:38 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Thu, 24 Nov 2023 19:29:39 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Fri, 25 Qqq 2023 20:30:40 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Mon, 01 Jan 20-5 08:00:00 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_HTTP, "Mon, 32 Jan 2018 08:00:00 GMT", 1'b1, 1'b0, '0},
        '{dsbt_pkg::FMT_ISO, "2018-01-01T08:00:00", 1'b1, 1'b1,
          {8'h18, 8'h01, 8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 1'b1}}
    };

    date_string_to_bcd_time u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_byte       (char_byte),
        .start_of_string (start_of_string),
        .end_of_string   (end_of_string),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .year_bcd        (year_bcd),
        .month_bcd       (month_bcd),
        .day_bcd         (day_bcd),
        .weekday         (weekday),
        .hour_bcd        (hour_bcd),
        .minute_bcd      (minute_bcd),
        .second_bcd      (second_bcd),
        .hundredth_bcd   (hundredth_bcd),
        .ok              (ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- decoder prediction ----------------

    function automatic logic [7:0] char_at(int i);
        return (i < MAX_CHARS) ? char_mem[i] : 8'h00;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // atoi on two characters: blank, sign, up to two digits
    function automatic int atoi_pair(logic [7:0] a, logic [7:0] b);
        if (blank_char(a))
            return digit_char(b) ? int'(b - ASCII_ZERO) : 0;
        if (digit_char(a))
        begin
            if (digit_char(b))
                return int'(a - ASCII_ZERO) * 10 + int'(b - ASCII_ZERO);
            return int'(a - ASCII_ZERO);
        end
        if (a == "+" && digit_char(b))
            return int'(b - ASCII_ZERO);
        if (a == "-" && digit_char(b))
            return -int'(b - ASCII_ZERO);
        return 0;
    endfunction

    function automatic logic [7:0] pair_byte(int i);
        return 8'(atoi_pair(char_at(i), char_at(i + 1)));
    endfunction

    function automatic logic [7:0] bin_to_bcd(logic [7:0] d);
        int q;
        q = d / 10;
        return 8'(q * 16 + d % 10);
    endfunction

    // stores fields in order until the first one out of range
    function automatic bit commit_fields(bit year_ok);
        if (!year_ok)
            return 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (cand[k] < FIELD_LO[k] || cand[k] > FIELD_HI[k])
                return 1'b0;
            held[k] = bin_to_bcd(cand[k]);
        end
        return 1'b1;
    endfunction

    function automatic bit decode_iso();
        cand[0] = pair_byte(2);
        cand[1] = pair_byte(5);
        cand[2] = pair_byte(8);
        cand[3] = 8'h00;
        cand[4] = pair_byte(11);
        cand[5] = pair_byte(14);
        cand[6] = pair_byte(17);
        cand[7] = 8'h00;
        return commit_fields(1'b1);
    endfunction

    function automatic bit decode_http();
        int         base;
        int         m;
        int         yr;
        logic [7:0] c;
        logic [7:0] wd;
        logic [7:0] mo;
        base = (char_at(0) == "D") ? 6 : 0;
        c = char_at(base);
        if (c == "T")
            wd = (char_at(base + 1) == "u") ? 8'd2 : 8'd4;
        else if (c == "S")
            wd = (char_at(base + 1) == "a") ? 8'd6 : 8'd0;
        else if (c == "M")
            wd = 8'd1;
        else if (c == "W")
            wd = 8'd3;
        else
            wd = 8'd5;
        m = base + 8;
        c = char_at(m);
        if (c == "J")
            mo = (char_at(m + 1) == "a") ? 8'd1 : ((char_at(m + 2) == "n") ? 8'd6 : 8'd7);
        else if (c == "F")
            mo = 8'd2;
        else if (c == "M")
            mo = (char_at(m + 2) == "r") ? 8'd3 : 8'd5;
        else if (c == "A")
            mo = (char_at(m + 1) == "p") ? 8'd4 : 8'd8;
        else if (c == "S")
            mo = 8'd9;
        else if (c == "O")
            mo = 8'd10;
        else if (c == "N")
            mo = 8'd11;
        else
            mo = 8'd12;
        // HTTP year keeps its sign: a negative pair fails before anything is stored
        yr = atoi_pair(char_at(base + 14), char_at(base + 15));
        cand[0] = 8'((yr < 0) ? 0 : yr);
        cand[1] = mo;
        cand[2] = pair_byte(base + 5);
        cand[3] = wd;
        cand[4] = pair_byte(base + 17);
        cand[5] = pair_byte(base + 20);
        cand[6] = pair_byte(base + 23);
        cand[7] = 8'h00;
        return commit_fields(yr >= 0);
    endfunction

    function automatic void take_char(logic [7:0] c, logic sos, logic eos);
        bit        passed;
        bcd_time_t t;
        if (sos)
        begin
            char_mem = '{default: 8'h00};
            char_pos = 0;
        end
        if (char_pos < MAX_CHARS)
        begin
            char_mem[char_pos] = c;
            char_pos++;
            chars_taken++;
        end
        if (eos)
        begin
            passed = fmt_http ? decode_http() : decode_iso();
            t = {held[0], held[1], held[2], held[3], held[4], held[5], held[6], held[7],
                 passed};
            if (pinned)
                t = pinned_want;
            pinned = 1'b0;
            times_due.push_back(t);
            decodes++;
            if (!passed)
                fails++;
            char_mem = '{default: 8'h00};
            char_pos = 0;
        end
    endfunction

    // ---------------- string builders ----------------

    function automatic void push_byte(int v);
        line_chars.push_back(8'(v));
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endfunction

    function automatic int pick_field(int lo, int hi);
        if ($urandom_range(99) < 8)
            return $urandom_range(99);
        return $urandom_range(hi, lo);
    endfunction

    // two-digit field, now and then in another form: blank, sign or random byte beside one digit
    function automatic void push_pair(int v);
        int form;
        form = $urandom_range(19);
        case (form)
            0:
            begin
                push_byte($urandom_range(1) ? " " : $urandom_range(13, 9));
                push_byte(ASCII_ZERO + v % 10);
            end
            1:
            begin
                push_byte("+");
                push_byte(ASCII_ZERO + v % 10);
            end
            2:
            begin
                push_byte("-");
                push_byte(ASCII_ZERO + v % 10);
            end
            3:
            begin
                push_byte(ASCII_ZERO + v % 10);
                push_byte($urandom_range(255));
            end
            4:
            begin
                push_byte($urandom_range(255));
                push_byte(ASCII_ZERO + v % 10);
            end
            default:
            begin
                push_byte(ASCII_ZERO + v / 10);
                push_byte(ASCII_ZERO + v % 10);
            end
        endcase
    endfunction

    function automatic void build_iso();
        push_text("20");
        push_pair($urandom_range(99));
        push_text("-");
        push_pair(pick_field(1, 12));
        push_text("-");
        push_pair(pick_field(1, 31));
        push_text("T");
        push_pair(pick_field(0, 23));
        push_text(":");
        push_pair(pick_field(0, 59));
        push_text(":");
        push_pair(pick_field(0, 59));
    endfunction

    function automatic void build_http();
        if ($urandom_range(2) == 0)
            push_text("Date: ");
        push_text(wd_names[$urandom_range(7)]);
        push_text(", ");
        push_pair(pick_field(1, 31));
        push_text(" ");
        push_text(mo_names[$urandom_range(12)]);
        push_text(" 20");
        push_pair($urandom_range(99));
        push_text(" ");
        push_pair(pick_field(0, 23));
        push_text(":");
        push_pair(pick_field(0, 59));
        push_text(":");
        push_pair(pick_field(0, 59));
        push_text(" GMT");
    endfunction

    // mostly well-formed strings, the rest noise, damaged, cut short (some in the other layout), unmarked or unended
    function automatic void make_random_line(output bit marked, output bit ended);
        int kind;
        int len;
        int keep;
        kind = $urandom_range(99);
        line_chars.delete();
        marked = 1'b1;
        ended = 1'b1;
        if (kind < 12)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            repeat (len) push_byte($urandom_range(255));
        end
        else
        begin
            if ((kind < 22) != fmt_http)
                build_http();
            else
                build_iso();
            if (kind >= 22 && kind < 34)
            begin
                repeat ($urandom_range(3, 1))
                    line_chars[$urandom_range(line_chars.size() - 1)] = 8'($urandom_range(255));
            end
            else if (kind < 42)
            begin
                keep = $urandom_range(line_chars.size(), 1);
                while (line_chars.size() > keep)
                    void'(line_chars.pop_back());
            end
            else if (kind < 46)
                marked = 1'b0;
            else if (kind < 49)
                ended = 1'b0;
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic send_char(input logic [7:0] c, input logic sos, input logic eos);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        char_byte       <= c;
        start_of_string <= sos;
        end_of_string   <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        take_char(c, sos, eos);
    endtask

    task automatic send_line(input bit marked, input bit ended, input bit stray_starts);
        int  last;
        logic sos;
        last = line_chars.size() - 1;
        for (int i = 0; i <= last; i++)
        begin
            sos = (i == 0 && marked) || (stray_starts && $urandom_range(199) == 0);
            send_char(line_chars[i], sos, ended && i == last);
        end
        strings_sent++;
    endtask

    // drop valid and let every pending result drain before touching the register
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (times_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dsbt_pkg::REG_FORMAT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        fmt_http = value[0];
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        bcd_time_t got;
        bcd_time_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {year_bcd, month_bcd, day_bcd, weekday, hour_bcd, minute_bcd,
                   second_bcd, hundredth_bcd, ok};
            results_seen++;
            if (times_due.size() == 0)
                report_mismatch("unexpected result, year_bcd", got.year, 0);
            else
            begin
                want = times_due.pop_front();
                if (got.year != want.year)
                    report_mismatch("year_bcd", got.year, want.year);
                if (got.month != want.month)
                    report_mismatch("month_bcd", got.month, want.month);
                if (got.day != want.day)
                    report_mismatch("day_bcd", got.day, want.day);
                if (got.wday != want.wday)
                    report_mismatch("weekday", got.wday, want.wday);
                if (got.hour != want.hour)
                    report_mismatch("hour_bcd", got.hour, want.hour);
                if (got.minute != want.minute)
                    report_mismatch("minute_bcd", got.minute, want.minute);
                if (got.second != want.second)
                    report_mismatch("second_bcd", got.second, want.second);
                if (got.hundredth != want.hundredth)
                    report_mismatch("hundredth_bcd", got.hundredth, want.hundredth);
                if (got.ok != want.ok)
                    report_mismatch("ok", got.ok, want.ok);
            end
        end
    end

    // a cycle with no transfer on any port counts toward the timeout
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- sequence ----------------

    initial
    begin
        bit          marked;
        bit          ended;
        int          n_str;
        int          char_goal;
        int          decode_goal;
        logic [31:0] value;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        char_byte       = 8'h00;
        start_of_string = 1'b0;
        end_of_string   = 1'b0;
        out_ready       = 1'b0;
        calm            = 1'b0;
        pinned          = 1'b0;
        fmt_http        = dsbt_pkg::FMT_ISO;
        char_mem        = '{default: 8'h00};
        held            = '{default: 8'h00};
        char_pos        = 0;
        errors          = 0;
        chars_taken     = 0;
        decodes         = 0;
        fails           = 0;
        results_seen    = 0;
        reg_writes      = 0;
        strings_sent    = 0;
        quiet_cycles    = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed strings; format switches use the all-zero and all-one words
        foreach (date_rows[r])
        begin
            if (date_rows[r].fmt != fmt_http)
            begin
                settle();
                write_format(date_rows[r].fmt ? 32'hFFFF_FFFF : 32'h0000_0000);
            end
            line_chars.delete();
            push_text(date_rows[r].text);
            pinned      = date_rows[r].pinned;
            pinned_want = date_rows[r].want;
            send_line(date_rows[r].marked, 1'b1, 1'b0);
        end

        // random strings in phases, each phase with its own format setting
        char_goal   = chars_taken + RANDOM_CHARS;
        decode_goal = decodes + RANDOM_DECODES;
        n_str = 0;
        while (chars_taken < char_goal || decodes < decode_goal)
        begin
            if (n_str % PHASE_STRINGS == 0)
            begin
                settle();
                value = $urandom;
                write_format(value);
            end
            // the first phase runs with no idling on either side
            calm = (n_str < PHASE_STRINGS);
            make_random_line(marked, ended);
            send_line(marked, ended, 1'b1);
            n_str++;
        end
        calm = 1'b0;

        settle();

        $display("%0d strings sent, %0d characters stored, %0d decodes (%0d with ok low)",
                 strings_sent, chars_taken, decodes, fails);
        $display("%0d results checked over %0d format register writes in both layouts",
                 results_seen, reg_writes);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== date_string_to_bcd_time.f =====
src/dsbt_pkg.sv
src/dsbt_front.sv
src/dsbt_queue.sv
src/dsbt_back.sv
src/date_string_to_bcd_time.sv
sim/tb_date_string_to_bcd_time.sv
